@@ src/bc1_bc2_bc3_block_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// BC1/BC2/BC3 block decoder assertion macros
// Shared concurrent assertion forms, clocked on clock, reset active high.
// ----------------------------------------------------------------------------
`ifndef BC1_BC2_BC3_BLOCK_DECODER_MACROS_SVH
`define BC1_BC2_BC3_BLOCK_DECODER_MACROS_SVH

// checked only outside reset
`define BC123_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define BC123_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ src/bc123_pkg.sv @@
// ----------------------------------------------------------------------------
// BC1/BC2/BC3 block decoder package
// Format codes, texel transaction type and helpers shared by the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bc123_pkg;

   localparam logic [1:0] FMT_BC1 = 2'd0;
   localparam logic [1:0] FMT_BC2 = 2'd1;
   localparam logic [1:0] FMT_BC3 = 2'd2;

   localparam int CH_RED   = 2;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 0;

   // floor(x / d) == (x * RECIP) >> SHIFT over the ranges used here
   localparam logic [9:0]  RECIP_THIRD   = 10'd683;
   localparam int          SHIFT_THIRD   = 11;
   localparam logic [11:0] RECIP_SEVENTH = 12'd2341;
   localparam int          SHIFT_SEVENTH = 14;
   localparam logic [10:0] RECIP_FIFTH   = 11'd1639;
   localparam int          SHIFT_FIFTH   = 13;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef logic [2:0][7:0] rgb_type;
   typedef logic [2:0][9:0] rgb_sum_type;

   typedef enum logic [2:0] {
      COLOR_E0,
      COLOR_E1,
      COLOR_THIRD_A,
      COLOR_THIRD_B,
      COLOR_HALF,
      COLOR_BLACK
   } color_sel_type;

   typedef enum logic [1:0] {
      ALPHA_DIRECT,
      ALPHA_DIV7,
      ALPHA_DIV5
   } alpha_sel_type;

   // one texel issued by the serializer
   typedef struct packed {
      logic        valid;
      logic [3:0]  index;
      logic        last;
      logic [1:0]  fmt;
      logic [15:0] color0;
      logic [15:0] color1;
      logic [1:0]  color_code;
      logic [2:0]  alpha_key;
      logic [3:0]  nibble;
      logic [7:0]  alpha0;
      logic [7:0]  alpha1;
   } texel_item_type;

   function automatic rgb_type widen565(input logic [15:0] c);
      rgb_type rgb;
      rgb[CH_RED]   = {c[15:11], 3'b000};
      rgb[CH_GREEN] = {c[10:5], 2'b00};
      rgb[CH_BLUE]  = {c[4:0], 3'b000};
      return rgb;
   endfunction

endpackage

`default_nettype wire

@@ src/bc123_serializer.sv @@
// ----------------------------------------------------------------------------
// BC1/BC2/BC3 block serializer
// Holds one compressed block and issues its sixteen texels, one per cycle while advance is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bc123_serializer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire logic [1:0]                format,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [63:0]               req_color_block,
   input  wire logic [63:0]               req_alpha_block,
   output bc123_pkg::texel_item_type      texel
);

   logic        busy_ff, busy_in;
   logic [3:0]  count_ff, count_in;
   logic [63:0] color_ff, color_in;
   logic [63:0] alpha_ff, alpha_in;
   logic [1:0]  fmt_ff, fmt_in;

   logic        take;
   logic        accept;
   logic [31:0] color_codes;
   logic [47:0] alpha_keys;
   logic [5:0]  alpha_pos;

   assign take      = advance && (!busy_ff || (count_ff == 4'd15));
   assign req_stall = !take;
   assign accept    = req_valid && take;

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      color_in = color_ff;
      alpha_in = alpha_ff;
      fmt_in   = fmt_ff;
      if (advance && busy_ff) begin
         count_in = count_ff + 4'd1;
         if (count_ff == 4'd15) begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in  = 1'b1;
         count_in = 4'd0;
         color_in = req_color_block;
         alpha_in = req_alpha_block;
         fmt_in   = format;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= 4'd0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      color_ff <= color_in;
      alpha_ff <= alpha_in;
      fmt_ff   <= fmt_in;
   end

   assign color_codes = color_ff[63:32];
   assign alpha_keys  = alpha_ff[63:16];
   assign alpha_pos   = {1'b0, count_ff, 1'b0} + {2'b00, count_ff};

   always_comb begin
      texel.valid      = busy_ff;
      texel.index      = count_ff;
      texel.last       = (count_ff == 4'd15);
      texel.fmt        = fmt_ff;
      texel.color0     = color_ff[15:0];
      texel.color1     = color_ff[31:16];
      texel.color_code = color_codes[{count_ff, 1'b0} +: 2];
      texel.alpha_key  = alpha_keys[alpha_pos +: 3];
      texel.nibble     = alpha_ff[{count_ff, 2'b00} +: 4];
      texel.alpha0     = alpha_ff[7:0];
      texel.alpha1     = alpha_ff[15:8];
   end

endmodule

`default_nettype wire

@@ src/bc123_texel_pipe.sv @@
// ----------------------------------------------------------------------------
// BC1/BC2/BC3 texel pipeline
// Three register stages: capture, endpoint sums, divide-and-select output.
// ----------------------------------------------------------------------------
`default_nettype none

module bc123_texel_pipe (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire bc123_pkg::texel_item_type texel,
   output logic                           advance,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [3:0]                     rsp_texel_index,
   output logic [7:0]                     rsp_red,
   output logic [7:0]                     rsp_green,
   output logic [7:0]                     rsp_blue,
   output logic [7:0]                     rsp_alpha,
   output logic                           rsp_last
);

   // stage 1: captured texel
   bc123_pkg::texel_item_type s1_ff;

   // stage 2: sums and selections
   logic                     s2_valid_ff, s2_valid_in;
   logic [3:0]               s2_index_ff, s2_index_in;
   logic                     s2_last_ff, s2_last_in;
   bc123_pkg::rgb_type       s2_e0_ff, s2_e0_in;
   bc123_pkg::rgb_type       s2_e1_ff, s2_e1_in;
   bc123_pkg::rgb_sum_type   s2_sum_a_ff, s2_sum_a_in;
   bc123_pkg::rgb_sum_type   s2_sum_b_ff, s2_sum_b_in;
   bc123_pkg::rgb_type       s2_half_ff, s2_half_in;
   bc123_pkg::color_sel_type s2_csel_ff, s2_csel_in;
   bc123_pkg::alpha_sel_type s2_asel_ff, s2_asel_in;
   logic [7:0]               s2_adirect_ff, s2_adirect_in;
   logic [10:0]              s2_asum_ff, s2_asum_in;

   // stage 3: output register
   logic                     out_valid_ff, out_valid_in;
   logic [3:0]               out_index_ff, out_index_in;
   logic                     out_last_ff, out_last_in;
   bc123_pkg::rgb_type       out_rgb_ff, out_rgb_in;
   logic [7:0]               out_alpha_ff, out_alpha_in;

   logic                     four_color;
   logic                     eight_level;
   logic [2:0]               w0, w1;
   logic [8:0]               pair_sum;
   logic [19:0]              prod_a, prod_b;
   logic [22:0]              prod_seventh;
   logic [21:0]              prod_fifth;

   assign advance = !(out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff.valid <= texel.valid;
      end
      if (advance) begin
         s1_ff.index      <= texel.index;
         s1_ff.last       <= texel.last;
         s1_ff.fmt        <= texel.fmt;
         s1_ff.color0     <= texel.color0;
         s1_ff.color1     <= texel.color1;
         s1_ff.color_code <= texel.color_code;
         s1_ff.alpha_key  <= texel.alpha_key;
         s1_ff.nibble     <= texel.nibble;
         s1_ff.alpha0     <= texel.alpha0;
         s1_ff.alpha1     <= texel.alpha1;
      end
   end

   always_comb begin
      s2_valid_in = s1_ff.valid;
      s2_index_in = s1_ff.index;
      s2_last_in  = s1_ff.last;
      s2_e0_in    = bc123_pkg::widen565(s1_ff.color0);
      s2_e1_in    = bc123_pkg::widen565(s1_ff.color1);
      four_color  = (s1_ff.fmt == bc123_pkg::FMT_BC2) || (s1_ff.fmt == bc123_pkg::FMT_BC3)
                    || (s1_ff.color0 > s1_ff.color1);
      pair_sum    = 9'd0;
      for (int ch = 0; ch < 3; ch++) begin
         s2_sum_a_in[ch] = {1'b0, s2_e0_in[ch], 1'b0} + {2'b00, s2_e1_in[ch]};
         s2_sum_b_in[ch] = {2'b00, s2_e0_in[ch]} + {1'b0, s2_e1_in[ch], 1'b0};
         pair_sum        = {1'b0, s2_e0_in[ch]} + {1'b0, s2_e1_in[ch]};
         s2_half_in[ch]  = pair_sum[8:1];
      end

      case (s1_ff.color_code)
         2'd0:    s2_csel_in = bc123_pkg::COLOR_E0;
         2'd1:    s2_csel_in = bc123_pkg::COLOR_E1;
         2'd2:    s2_csel_in = four_color ? bc123_pkg::COLOR_THIRD_A : bc123_pkg::COLOR_HALF;
         default: s2_csel_in = four_color ? bc123_pkg::COLOR_THIRD_B : bc123_pkg::COLOR_BLACK;
      endcase

      eight_level   = s1_ff.alpha0 > s1_ff.alpha1;
      w0            = 3'd0;
      w1            = 3'd0;
      s2_asel_in    = bc123_pkg::ALPHA_DIRECT;
      s2_adirect_in = bc123_pkg::ALPHA_OPAQUE;
      case (s1_ff.fmt)
         bc123_pkg::FMT_BC2: begin
            s2_adirect_in = {s1_ff.nibble, s1_ff.nibble};
         end
         bc123_pkg::FMT_BC3: begin
            case (s1_ff.alpha_key)
               3'd0: s2_adirect_in = s1_ff.alpha0;
               3'd1: s2_adirect_in = s1_ff.alpha1;
               default: begin
                  if (eight_level) begin
                     s2_asel_in = bc123_pkg::ALPHA_DIV7;
                     w0         = 3'd0 - s1_ff.alpha_key;
                     w1         = s1_ff.alpha_key - 3'd1;
                  end else if (s1_ff.alpha_key == 3'd6) begin
                     s2_adirect_in = 8'd0;
                  end else if (s1_ff.alpha_key == 3'd7) begin
                     s2_adirect_in = bc123_pkg::ALPHA_OPAQUE;
                  end else begin
                     s2_asel_in = bc123_pkg::ALPHA_DIV5;
                     w0         = 3'd6 - s1_ff.alpha_key;
                     w1         = s1_ff.alpha_key - 3'd1;
                  end
               end
            endcase
         end
         default: begin
            s2_adirect_in = bc123_pkg::ALPHA_OPAQUE;
         end
      endcase
      s2_asum_in = 11'(w0) * 11'(s1_ff.alpha0) + 11'(w1) * 11'(s1_ff.alpha1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s2_valid_in;
      end
      if (advance) begin
         s2_index_ff   <= s2_index_in;
         s2_last_ff    <= s2_last_in;
         s2_e0_ff      <= s2_e0_in;
         s2_e1_ff      <= s2_e1_in;
         s2_sum_a_ff   <= s2_sum_a_in;
         s2_sum_b_ff   <= s2_sum_b_in;
         s2_half_ff    <= s2_half_in;
         s2_csel_ff    <= s2_csel_in;
         s2_asel_ff    <= s2_asel_in;
         s2_adirect_ff <= s2_adirect_in;
         s2_asum_ff    <= s2_asum_in;
      end
   end

   always_comb begin
      out_valid_in = s2_valid_ff;
      out_index_in = s2_index_ff;
      out_last_in  = s2_last_ff;
      prod_a       = 20'd0;
      prod_b       = 20'd0;
      for (int ch = 0; ch < 3; ch++) begin
         prod_a = 20'(s2_sum_a_ff[ch]) * 20'(bc123_pkg::RECIP_THIRD);
         prod_b = 20'(s2_sum_b_ff[ch]) * 20'(bc123_pkg::RECIP_THIRD);
         case (s2_csel_ff)
            bc123_pkg::COLOR_E0:      out_rgb_in[ch] = s2_e0_ff[ch];
            bc123_pkg::COLOR_E1:      out_rgb_in[ch] = s2_e1_ff[ch];
            bc123_pkg::COLOR_THIRD_A:
               out_rgb_in[ch] = prod_a[bc123_pkg::SHIFT_THIRD +: 8];
            bc123_pkg::COLOR_THIRD_B:
               out_rgb_in[ch] = prod_b[bc123_pkg::SHIFT_THIRD +: 8];
            bc123_pkg::COLOR_HALF:    out_rgb_in[ch] = s2_half_ff[ch];
            default:                  out_rgb_in[ch] = 8'd0;
         endcase
      end

      prod_seventh = 23'(s2_asum_ff) * 23'(bc123_pkg::RECIP_SEVENTH);
      prod_fifth   = 22'(s2_asum_ff) * 22'(bc123_pkg::RECIP_FIFTH);
      case (s2_asel_ff)
         bc123_pkg::ALPHA_DIV7: out_alpha_in = prod_seventh[bc123_pkg::SHIFT_SEVENTH +: 8];
         bc123_pkg::ALPHA_DIV5: out_alpha_in = prod_fifth[bc123_pkg::SHIFT_FIFTH +: 8];
         default:               out_alpha_in = s2_adirect_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         out_index_ff <= out_index_in;
         out_last_ff  <= out_last_in;
         out_rgb_ff   <= out_rgb_in;
         out_alpha_ff <= out_alpha_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_texel_index = out_index_ff;
   assign rsp_last        = out_last_ff;
   assign rsp_red         = out_rgb_ff[bc123_pkg::CH_RED];
   assign rsp_green       = out_rgb_ff[bc123_pkg::CH_GREEN];
   assign rsp_blue        = out_rgb_ff[bc123_pkg::CH_BLUE];
   assign rsp_alpha       = out_alpha_ff;

endmodule

`default_nettype wire

@@ src/bc1_bc2_bc3_block_decoder.sv @@
// ----------------------------------------------------------------------------
// BC1/BC2/BC3 block decoder
// Decompresses one 4x4 S3TC block per request into sixteen RGBA8 texels.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one transaction carries a compressed block, a
//   64-bit color half and a 64-bit alpha half.
//   Response channel (rsp_*): sixteen transactions per block, texel index 0
//   to 15 in raster order, rsp_last set on index 15.
//   csr_write_data selects the format (BC1, BC2, BC3; code 3 decodes as BC1);
//   write it only while no block is in flight. It is sampled per block.
//   Path: a request is registered in the serializer, then each texel passes the capture, sum and output registers.
//   Throughput: one texel per cycle while not stalled; the next block is
//   taken on the cycle the sixteenth texel of the current one issues, so
//   blocks stream gap-free.
//   Stall: rsp_stall with rsp_valid set freezes the whole pipeline, output register included;
//   nothing is dropped or repeated, and req_stall rises while frozen.
//   Reset (synchronous): clears all valid bits, the texel counter and the
//   format register (BC1).
// ----------------------------------------------------------------------------
`default_nettype none

module bc1_bc2_bc3_block_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_color_block,
   input  wire logic [63:0] req_alpha_block,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_texel_index,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_alpha,
   output logic             rsp_last
);

   logic [1:0]                format_ff, format_in;
   logic                      advance;
   bc123_pkg::texel_item_type texel;

   always_comb begin
      format_in = format_ff;
      if (csr_write_enable) begin
         format_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= bc123_pkg::FMT_BC1;
      end else begin
         format_ff <= format_in;
      end
   end

   bc123_serializer u_serializer (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .format          (format_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_color_block (req_color_block),
      .req_alpha_block (req_alpha_block),
      .texel           (texel)
   );

   bc123_texel_pipe u_texel_pipe (
      .clock           (clock),
      .reset           (reset),
      .texel           (texel),
      .advance         (advance),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_texel_index (rsp_texel_index),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_alpha       (rsp_alpha),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

@@ src/bc123_checker.sv @@
// ----------------------------------------------------------------------------
// BC1/BC2/BC3 block decoder checker
// Port-level assertions on response ordering, stall behavior and reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bc1_bc2_bc3_block_decoder_macros.svh"

module bc123_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [3:0]  rsp_texel_index,
   input  wire logic [7:0]  rsp_red,
   input  wire logic [7:0]  rsp_green,
   input  wire logic [7:0]  rsp_blue,
   input  wire logic [7:0]  rsp_alpha,
   input  wire logic        rsp_last
);

   // expected texel index of the next response transaction
   logic [3:0] expect_ff, expect_in;

   always_comb begin
      expect_in = expect_ff;
      if (rsp_valid && !rsp_stall) begin
         expect_in = expect_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff <= 4'd0;
      end else begin
         expect_ff <= expect_in;
      end
   end

   `BC123_ASSERT(a_stall_holds_valid, rsp_valid && rsp_stall |=> rsp_valid, "rsp_valid dropped while stalled")

   `BC123_ASSERT(a_stall_holds_data, rsp_valid && rsp_stall |=> $stable(rsp_texel_index) && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_alpha) && $stable(rsp_last), "response payload changed while stalled")

   `BC123_ASSERT(a_texel_order, rsp_valid |-> rsp_texel_index == expect_ff, "texel out of raster order")

   `BC123_ASSERT(a_last_on_final, rsp_valid |-> rsp_last == (rsp_texel_index == 4'd15), "rsp_last not on final texel")

   `BC123_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "rsp_valid set after reset")

endmodule

bind bc1_bc2_bc3_block_decoder bc123_checker u_checker (.*);

`default_nettype wire
